// ===== rtl/bf3_pkg.sv =====
// Shared types and constants of the 3x3 box filter.
`default_nettype none

package bf3_pkg;

  // Field widths of the pixel, result and configuration transactions.
  localparam int PIXEL_W   = 8;
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int CFG_IDX_W = 2;

  // Frame geometry limits and register reset values.
  localparam int               DEF_MAX_WIDTH = 4096;
  localparam int               HEIGHT_LIMIT  = 4096;
  localparam int               MIN_DIM       = 3;
  localparam logic [DIM_W-1:0] WIDTH_RESET   = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET  = 13'd480;

  // Window arithmetic: one column sum is at most 765, the full window at most 2295.
  localparam int COL_SUM_W = 10;
  localparam int SUM_W     = 12;
  localparam int NUM_CELLS = 2;

  // Division by nine as a multiply by round-up(2^15 / 9) and a right shift.
  localparam int               RECIP_W     = 12;
  localparam logic [RECIP_W-1:0] RECIP_9   = 12'd3641;
  localparam int               RECIP_SHIFT = 15;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/bf3_if.sv =====
// Handshake channels of the 3x3 box filter: pixels, results and configuration.
`default_nettype none

interface bf3_pix_if import bf3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bf3_res_if import bf3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] filtered_value;
  logic [COORD_W-1:0] center_column;
  logic [COORD_W-1:0] center_row;
  logic               frame_last;

  modport source (output valid, output filtered_value, output center_column,
                  output center_row, output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input center_column,
                  input center_row, input frame_last, output ready);
endinterface

interface bf3_cfg_if import bf3_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bf3_cell.sv =====
// One window cell: holds the sum of one three-pixel column and passes it on.
`default_nettype none

module bf3_cell import bf3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [COL_SUM_W-1:0] sum_i,
  output logic [COL_SUM_W-1:0] sum_o
);

  logic [COL_SUM_W-1:0] sum_q;

  // Take the neighbor's column sum whenever the window moves one column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (shift_i) begin
      sum_q <= sum_i;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/bf3_div9.sv =====
// Registered truncating division of the window sum by nine.
`default_nettype none

module bf3_div9 import bf3_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SUM_W-1:0]   sum_i,
  output logic [PIXEL_W-1:0] quot_o
);

  logic [SUM_W+RECIP_W-1:0] product;
  logic [PIXEL_W-1:0]       quot_q;

  // The reciprocal error stays below 1/9 over the whole sum range, so the floor is exact.
  assign product = (SUM_W+RECIP_W)'(sum_i) * (SUM_W+RECIP_W)'(RECIP_9);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= product[RECIP_SHIFT +: PIXEL_W];
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/box_filter_3x3_gray_core.sv =====
// Streaming 3x3 mean filter for 8-bit grayscale frames in raster order.
// Throughput: one pixel per clock unless output stalls; the line store is one read
// and one write port; each result passes stage 1, stage 2 and the output register.
// Reset clears counters, window cells and valid bits and loads width 640, height 480.
// The line store is not cleared; reads of unwritten entries reach no result.
`default_nettype none

module box_filter_3x3_gray_core import bf3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bf3_pix_if.sink       pix_i,
  bf3_res_if.source     res_o,
  bf3_cfg_if.sink       cfg_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Last column and last row after clamping the frame size to its legal range.
  logic [CW-1:0]      w_last;
  logic [COORD_W-1:0] h_last;

  always_comb begin
    if (width_q < DIM_W'(MIN_DIM)) begin
      w_last = CW'(MIN_DIM - 1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(width_q - 1'b1);
    end
    if (height_q < DIM_W'(MIN_DIM)) begin
      h_last = COORD_W'(MIN_DIM - 1);
    end else if (32'(height_q) > HEIGHT_LIMIT) begin
      h_last = COORD_W'(HEIGHT_LIMIT - 1);
    end else begin
      h_last = COORD_W'(height_q - 1'b1);
    end
  end

  // The whole pipeline moves together whenever the output register is free.
  logic out_valid_q;
  logic adv, accept;

  assign adv         = !out_valid_q || res_o.ready;
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;

  // Raster position of the incoming pixel.
  logic [CW-1:0]      col_count_q, col;
  logic [COORD_W-1:0] row_count_q, row;
  logic               has_res, is_last;

  always_comb begin
    col     = (col_count_q >= w_last) ? w_last : col_count_q;
    row     = (row_count_q >= h_last) ? h_last : row_count_q;
    has_res = (col >= CW'(2)) && (row >= COORD_W'(2));
    is_last = (col == w_last) && (row == h_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (accept) begin
      if (col >= w_last) begin
        col_count_q <= '0;
        row_count_q <= (row >= h_last) ? '0 : row + 1'b1;
      end else begin
        col_count_q <= col + 1'b1;
      end
    end
  end

  // Stage 1 holds the accepted pixel while the line store read completes.
  logic               s1_valid_q, s1_res_q, s1_last_q;
  logic [PIXEL_W-1:0] s1_px_q;
  logic [CW-1:0]      s1_idx_q;
  logic [COORD_W-1:0] s1_ccol_q, s1_crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pix_i.pixel_in;
      s1_idx_q  <= col;
      s1_res_q  <= has_res;
      s1_last_q <= is_last;
      s1_ccol_q <= COORD_W'(col - CW'(1));
      s1_crow_q <= row - COORD_W'(1);
    end
  end

  // Line store: upper line in the high byte, middle line in the low byte.
  logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_W-1:0] rd_q;
  logic [PIXEL_W-1:0]   top_px, mid_px;

  assign top_px = rd_q[2*PIXEL_W-1:PIXEL_W];
  assign mid_px = rd_q[PIXEL_W-1:0];

  // Consecutive pixels use different columns, so the read never meets the write.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= line_mem[col];
    end
    if (adv && s1_valid_q) begin
      line_mem[s1_idx_q] <= {mid_px, s1_px_q};
    end
  end

  // Chain of window cells holding the two previous column sums.
  logic [COL_SUM_W-1:0] col_sum;
  logic [COL_SUM_W-1:0] cell_in  [NUM_CELLS];
  logic [COL_SUM_W-1:0] cell_out [NUM_CELLS];
  logic                 shift;
  logic [SUM_W-1:0]     win_sum;

  assign col_sum = COL_SUM_W'(top_px) + COL_SUM_W'(mid_px) + COL_SUM_W'(s1_px_q);
  assign shift   = adv && s1_valid_q;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = col_sum;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end
    bf3_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .sum_i  (cell_in[i]),
      .sum_o  (cell_out[i])
    );
  end

  always_comb begin
    win_sum = SUM_W'(col_sum);
    for (int i = 0; i < NUM_CELLS; i++) begin
      win_sum = win_sum + SUM_W'(cell_out[i]);
    end
  end

  // Stage 2 holds the window sum; it is valid for interior pixels only.
  logic               s2_valid_q, s2_last_q;
  logic [SUM_W-1:0]   s2_sum_q;
  logic [COORD_W-1:0] s2_ccol_q, s2_crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_q  <= win_sum;
      s2_ccol_q <= s1_ccol_q;
      s2_crow_q <= s1_crow_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Output register with the division by nine.
  logic [COORD_W-1:0] out_ccol_q, out_crow_q;
  logic               out_last_q;
  logic [PIXEL_W-1:0] quot;

  bf3_div9 u_div9 (
    .clk_i (clk_i),
    .en_i  (adv),
    .sum_i (s2_sum_q),
    .quot_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ccol_q <= s2_ccol_q;
      out_crow_q <= s2_crow_q;
      out_last_q <= s2_last_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.filtered_value = quot;
  assign res_o.center_column  = out_ccol_q;
  assign res_o.center_row     = out_crow_q;
  assign res_o.frame_last     = out_last_q;

  // The frame end is flagged only on the last interior row.
  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_crow_q == h_last - COORD_W'(1)))
    else $error("frame_last outside the last interior row");

  // An interior pixel in stage 1 always reaches stage 2 when the pipeline moves.
  a_s2_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_res_q && adv) |=> s2_valid_q)
    else $error("interior pixel dropped between stages");

  // A stalled pipeline keeps its window sum and its raster position.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s2_sum_q) && $stable(col_count_q) && $stable(row_count_q)))
    else $error("pipeline state changed during a stall");

endmodule

`default_nettype wire
